// File: rtl/pdsc_pkg.sv
// Shared types, constants and the microcode program of the straight-drive PI controller.
package pdsc_pkg;

    localparam int HISTORY_DEPTH_DEF = 40;

    // Configuration register map (index = byte address / 4).
    localparam int CFG_AW = 5;
    localparam logic [2:0] REG_TARGET   = 3'd0;
    localparam logic [2:0] REG_PROP     = 3'd1;
    localparam logic [2:0] REG_INTEG    = 3'd2;
    localparam logic [2:0] REG_STRAIGHT = 3'd3;
    localparam logic [2:0] REG_MPC      = 3'd4;
    localparam logic [2:0] REG_SETTLE   = 3'd5;

    localparam logic [15:0] RST_TARGET   = 16'd0;
    localparam logic [15:0] RST_PROP     = 16'd256;
    localparam logic [15:0] RST_INTEG    = 16'd26;
    localparam logic [15:0] RST_STRAIGHT = 16'd256;
    localparam logic [15:0] RST_MPC      = 16'd23561;
    localparam logic [15:0] RST_SETTLE   = 16'd6554;

    // Arithmetic limits, u and the sides are held in 1/256 percent.
    localparam logic signed [49:0] ERR_MAX   = 50'sd131071;
    localparam logic signed [49:0] ERR_MIN   = -50'sd131072;
    localparam logic signed [49:0] INTEG_WIN = 50'sd17920;
    localparam logic signed [49:0] U_LIM     = 50'sd15360;
    localparam logic signed [49:0] SIDE_LIM  = 50'sd25600;
    localparam logic signed [17:0] FILL_ERR  = 18'sd9999;

    // Sequencer program counter.
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_START = 4'd0;
    localparam logic [PC_W-1:0] PC_RST   = 4'd9;
    localparam logic [PC_W-1:0] PC_DONE  = 4'd10;

    typedef enum logic [2:0] {
        MS_HOLD,
        MS_POS,
        MS_KP,
        MS_KI,
        MS_KS,
        MS_TOL
    } t_mul_sel;

    typedef enum logic [1:0] {
        AC_HOLD,
        AC_POS,
        AC_LOAD,
        AC_ADD
    } t_acc_op;

    typedef enum logic [1:0] {
        OK_NONE,
        OK_RUN,
        OK_RESTART,
        OK_DONE
    } t_out_kind;

    typedef struct packed {
        logic      dispatch;
        t_mul_sel  mul;
        t_acc_op   acc;
        logic      err_en;
        logic      u_en;
        logic      side_en;
        t_out_kind okind;
    } t_uword;

    localparam t_uword UW_NOP = '{
        dispatch: 1'b0, mul: MS_HOLD, acc: AC_HOLD,
        err_en: 1'b0, u_en: 1'b0, side_en: 1'b0, okind: OK_NONE
    };

    typedef struct packed {
        logic [15:0] target;
        logic [15:0] prop;
        logic [15:0] integ;
        logic [15:0] straight;
        logic [15:0] mpc;
        logic [15:0] settle;
    } t_cfg;

    typedef struct packed {
        logic   load;
        t_uword uw;
    } t_dp_ctl;

    typedef struct packed {
        logic restart;
        logic done;
    } t_dp_stat;

    // Control store: one word per step of the sample, restart and settled-tick paths.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = UW_NOP;
        case (pc)
            4'd0: begin
                w.dispatch = 1'b1;
                w.mul      = MS_POS;
            end
            4'd1: w.acc = AC_POS;
            4'd2: w.err_en = 1'b1;
            4'd3: w.mul = MS_KP;
            4'd4: begin
                w.acc = AC_LOAD;
                w.mul = MS_KI;
            end
            4'd5: begin
                w.acc = AC_ADD;
                w.mul = MS_KS;
            end
            4'd6: w.u_en = 1'b1;
            4'd7: begin
                w.side_en = 1'b1;
                w.mul     = MS_TOL;
            end
            4'd8:  w.okind = OK_RUN;
            4'd9:  w.okind = OK_RESTART;
            4'd10: w.okind = OK_DONE;
            default: w = UW_NOP;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/pdsc_datapath.sv
// Datapath of the drive controller: shared multiplier, accumulator, history ring and result.
module pdsc_datapath #(
    parameter int HISTORY_DEPTH = pdsc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  pdsc_pkg::t_cfg           i_cfg,
    input  pdsc_pkg::t_dp_ctl        i_ctl,
    input  logic                     i_action,
    input  logic signed [23:0]       i_left_count,
    input  logic signed [23:0]       i_right_count,
    output pdsc_pkg::t_dp_stat       o_stat,
    output logic signed [13:0]       o_left_drive,
    output logic signed [13:0]       o_right_drive,
    output logic signed [6:0]        o_control_effort,
    output logic                     o_settled
);

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

    // Input word.
    logic              r_action;
    logic signed [23:0] r_left, r_right;

    // Arithmetic state.
    logic signed [49:0] r_p, r_acc;
    logic signed [17:0] r_err;
    logic signed [31:0] r_integ;
    logic signed [15:0] r_u, r_side_l, r_side_r;
    logic               r_done;

    // History ring.
    logic [17:0]              r_hist [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_vld;
    logic [PTR_W-1:0]         r_ptr;
    logic [17:0]              r_old;
    logic                     r_old_vld;

    logic signed [24:0] sum, diff;
    logic signed [32:0] op_a;
    logic signed [16:0] op_b;
    logic signed [49:0] prod;
    logic [15:0]        t_abs;
    logic [PTR_W-1:0]   nxt;
    logic signed [49:0] acc_bias, quot;
    logic signed [17:0] err_sat;
    logic signed [32:0] integ_sum;
    logic signed [31:0] integ_sat;
    logic signed [15:0] u_clamp;
    logic signed [49:0] u_ext, sum_l, sum_r;
    logic signed [15:0] side_l, side_r;
    logic signed [17:0] older;
    logic [17:0]        abs_err, abs_old;
    logic [33:0]        tol;
    logic               settle_hit;
    logic               fin_run, fin_rst, fin_done;

    function automatic logic [17:0] abs18(input logic signed [17:0] v);
        return v[17] ? 18'(-v) : v;
    endfunction

    // Clamp a wide value to a symmetric limit that fits 16 bits.
    function automatic logic signed [15:0] clamp16(input logic signed [49:0] v,
                                                  input logic signed [49:0] lim);
        logic signed [49:0] c;
        c = (v > lim) ? lim : ((v < -lim) ? -lim : v);
        return c[15:0];
    endfunction

    // side * 50 / 256, rounded toward zero.
    function automatic logic signed [13:0] to_drive(input logic signed [15:0] s);
        logic signed [21:0] se, x;
        se = {{6{s[15]}}, s};
        x  = (se <<< 5) + (se <<< 4) + (se <<< 1);
        x  = x + (x[21] ? 22'sd255 : 22'sd0);
        x  = x >>> 8;
        return x[13:0];
    endfunction

    // u / 256, rounded toward zero.
    function automatic logic signed [6:0] to_effort(input logic signed [15:0] v);
        logic signed [15:0] x;
        x = v + (v[15] ? 16'sd255 : 16'sd0);
        x = x >>> 8;
        return x[6:0];
    endfunction

    assign sum   = {r_left[23], r_left} + {r_right[23], r_right};
    assign diff  = {r_right[23], r_right} - {r_left[23], r_left};
    assign t_abs = i_cfg.target[15] ? 16'(-i_cfg.target) : i_cfg.target;
    assign nxt   = (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_ctl.uw.mul)
            pdsc_pkg::MS_POS: begin
                op_a = {{8{sum[24]}}, sum};
                op_b = {1'b0, i_cfg.mpc};
            end
            pdsc_pkg::MS_KP: begin
                op_a = {{15{r_err[17]}}, r_err};
                op_b = {1'b0, i_cfg.prop};
            end
            pdsc_pkg::MS_KI: begin
                op_a = {r_integ[31], r_integ};
                op_b = {1'b0, i_cfg.integ};
            end
            pdsc_pkg::MS_KS: begin
                op_a = {{8{diff[24]}}, diff};
                op_b = {1'b0, i_cfg.straight};
            end
            pdsc_pkg::MS_TOL: begin
                op_a = {17'd0, t_abs};
                op_b = {1'b0, i_cfg.settle};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = op_a * op_b;

    // Error: truncate toward zero, then saturate to 18 bits.
    assign acc_bias = r_acc + (r_acc[49] ? 50'sd131071 : 50'sd0);
    assign quot     = acc_bias >>> 17;
    assign err_sat  = (quot > pdsc_pkg::ERR_MAX) ? 18'sh1ffff :
                      ((quot < pdsc_pkg::ERR_MIN) ? 18'sh20000 : quot[17:0]);

    // Conditional integration with 32-bit saturation.
    assign integ_sum = {r_integ[31], r_integ} + {{15{r_err[17]}}, r_err};
    assign integ_sat = (integ_sum[32] != integ_sum[31]) ?
                       (integ_sum[32] ? 32'sh80000000 : 32'sh7fffffff) : integ_sum[31:0];
    assign u_clamp   = clamp16(r_acc, pdsc_pkg::U_LIM);

    assign u_ext  = {{34{r_u[15]}}, r_u};
    assign sum_l  = u_ext + r_p;
    assign sum_r  = u_ext - r_p;
    assign side_l = clamp16(sum_l, pdsc_pkg::SIDE_LIM);
    assign side_r = clamp16(sum_r, pdsc_pkg::SIDE_LIM);

    assign older      = r_old_vld ? r_old : pdsc_pkg::FILL_ERR;
    assign abs_err    = abs18(r_err);
    assign abs_old    = abs18(older);
    assign tol        = {2'b00, r_p[31:0]};
    assign settle_hit = ({abs_err, 16'd0} <= tol) && ({abs_old, 16'd0} <= tol);

    assign fin_run  = (i_ctl.uw.okind == pdsc_pkg::OK_RUN);
    assign fin_rst  = (i_ctl.uw.okind == pdsc_pkg::OK_RESTART);
    assign fin_done = (i_ctl.uw.okind == pdsc_pkg::OK_DONE);

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_action <= i_action;
            r_left   <= i_left_count;
            r_right  <= i_right_count;
        end
        if (i_ctl.uw.mul != pdsc_pkg::MS_HOLD) begin
            r_p <= prod;
        end
        case (i_ctl.uw.acc)
            pdsc_pkg::AC_POS:  r_acc <= {{17{i_cfg.target[15]}}, i_cfg.target, 17'd0} - r_p;
            pdsc_pkg::AC_LOAD: r_acc <= r_p;
            pdsc_pkg::AC_ADD:  r_acc <= r_acc + r_p;
            default:           r_acc <= r_acc;
        endcase
        if (i_ctl.uw.err_en) begin
            r_err <= err_sat;
        end
        if (i_ctl.uw.u_en) begin
            r_u <= u_clamp;
        end
        if (i_ctl.uw.side_en) begin
            r_side_l <= side_l;
            r_side_r <= side_r;
        end
        if (fin_run) begin
            r_hist[r_ptr] <= r_err;
        end
        r_old <= r_hist[nxt];
        if (fin_run) begin
            o_control_effort <= to_effort(r_u);
            o_settled        <= settle_hit;
            o_left_drive     <= settle_hit ? 14'sd0 : to_drive(r_side_l);
            o_right_drive    <= settle_hit ? 14'sd0 : to_drive(r_side_r);
        end else if (fin_rst || fin_done) begin
            o_control_effort <= 7'sd0;
            o_settled        <= fin_done;
            o_left_drive     <= 14'sd0;
            o_right_drive    <= 14'sd0;
        end
    end

    // Run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ   <= '0;
            r_vld     <= '0;
            r_ptr     <= '0;
            r_done    <= 1'b0;
            r_old_vld <= 1'b0;
        end else begin
            r_old_vld <= r_vld[nxt];
            if (fin_rst) begin
                r_integ <= '0;
                r_vld   <= '0;
                r_ptr   <= '0;
                r_done  <= 1'b0;
            end else begin
                if (i_ctl.uw.u_en && (r_acc > -pdsc_pkg::INTEG_WIN)
                        && (r_acc < pdsc_pkg::INTEG_WIN)) begin
                    r_integ <= integ_sat;
                end
                if (fin_run) begin
                    r_vld[r_ptr] <= 1'b1;
                    r_ptr        <= nxt;
                    if (settle_hit) begin
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_stat.restart = r_action;
    assign o_stat.done    = r_done;

endmodule

// File: rtl/pi_drive_with_straight_correction_core.sv
// Top level of the straight-drive PI controller: register port, sequencer and handshakes.
// A sample tick runs the nine-step program on one shared multiplier from acceptance to a
// valid result word; a restart or a tick after settling runs step 0 and one closing step.
// A new word is accepted the cycle after the previous one finishes, never during a tick.
// Reset (synchronous, active low) loads the register defaults, clears the integral, the
// history valid bits, the ring pointer and the settled flag; no clearing pass is needed.
module pi_drive_with_straight_correction_core #(
    parameter int HISTORY_DEPTH = pdsc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Register port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pdsc_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // Input words.
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_action,
    input  logic signed [23:0]           i_left_count,
    input  logic signed [23:0]           i_right_count,
    // Result words.
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [13:0]           o_left_drive,
    output logic signed [13:0]           o_right_drive,
    output logic signed [6:0]            o_control_effort,
    output logic                         o_settled
);

    pdsc_pkg::t_cfg      r_cfg;
    pdsc_pkg::t_dp_ctl   ctl;
    pdsc_pkg::t_dp_stat  stat;
    pdsc_pkg::t_uword    uw_rom;

    logic                       r_busy;
    logic [pdsc_pkg::PC_W-1:0]  r_pc;
    logic                       r_out_valid;
    logic [2:0]                 reg_idx;
    logic                       cfg_wr;
    logic                       fin_step, out_free, go, fire;

    // The register port never waits. Writes land on the access cycle.
    assign pready  = 1'b1;
    assign reg_idx = paddr[pdsc_pkg::CFG_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target   <= pdsc_pkg::RST_TARGET;
            r_cfg.prop     <= pdsc_pkg::RST_PROP;
            r_cfg.integ    <= pdsc_pkg::RST_INTEG;
            r_cfg.straight <= pdsc_pkg::RST_STRAIGHT;
            r_cfg.mpc      <= pdsc_pkg::RST_MPC;
            r_cfg.settle   <= pdsc_pkg::RST_SETTLE;
        end else if (cfg_wr) begin
            case (reg_idx)
                pdsc_pkg::REG_TARGET:   r_cfg.target   <= pwdata[15:0];
                pdsc_pkg::REG_PROP:     r_cfg.prop     <= pwdata[15:0];
                pdsc_pkg::REG_INTEG:    r_cfg.integ    <= pwdata[15:0];
                pdsc_pkg::REG_STRAIGHT: r_cfg.straight <= pwdata[15:0];
                pdsc_pkg::REG_MPC:      r_cfg.mpc      <= pwdata[15:0];
                pdsc_pkg::REG_SETTLE:   r_cfg.settle   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pdsc_pkg::REG_TARGET:   prdata = {16'd0, r_cfg.target};
            pdsc_pkg::REG_PROP:     prdata = {16'd0, r_cfg.prop};
            pdsc_pkg::REG_INTEG:    prdata = {16'd0, r_cfg.integ};
            pdsc_pkg::REG_STRAIGHT: prdata = {16'd0, r_cfg.straight};
            pdsc_pkg::REG_MPC:      prdata = {16'd0, r_cfg.mpc};
            pdsc_pkg::REG_SETTLE:   prdata = {16'd0, r_cfg.settle};
            default:                prdata = 32'd0;
        endcase
    end

    // Sequencer. The control store is read at the program counter every cycle. The last
    // step of each path writes the result register, so it waits while an earlier result
    // is still stalled there; every other step advances unconditionally. Step 0 branches
    // to the restart path or to the already-settled path.
    assign uw_rom   = pdsc_pkg::ucode(r_pc);
    assign fin_step = (uw_rom.okind != pdsc_pkg::OK_NONE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign go       = r_busy && (!fin_step || out_free);
    assign fire     = go && fin_step;

    assign o_in_stall = r_busy;
    assign ctl.load   = i_in_valid && !r_busy;
    assign ctl.uw     = go ? uw_rom : pdsc_pkg::UW_NOP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= pdsc_pkg::PC_START;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (ctl.load) begin
                r_busy <= 1'b1;
                r_pc   <= pdsc_pkg::PC_START;
            end else if (go) begin
                if (fire) begin
                    r_busy <= 1'b0;
                    r_pc   <= pdsc_pkg::PC_START;
                end else if (uw_rom.dispatch) begin
                    if (stat.restart) begin
                        r_pc <= pdsc_pkg::PC_RST;
                    end else if (stat.done) begin
                        r_pc <= pdsc_pkg::PC_DONE;
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end else begin
                    r_pc <= r_pc + 1'b1;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // Multiplier, accumulator, error history and the result register.
    pdsc_datapath #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_ctl            (ctl),
        .i_action         (i_action),
        .i_left_count     (i_left_count),
        .i_right_count    (i_right_count),
        .o_stat           (stat),
        .o_left_drive     (o_left_drive),
        .o_right_drive    (o_right_drive),
        .o_control_effort (o_control_effort),
        .o_settled        (o_settled)
    );

endmodule

// File: sim/pi_drive_with_straight_correction_core_tb.sv
// Self-checking testbench for the straight-drive PI controller core.
module pi_drive_with_straight_correction_core_tb;

    // Ring depth of the settle history, the same default the core uses.
    localparam int HIST = pdsc_pkg::HISTORY_DEPTH_DEF;

    // Arithmetic limits of the controller. u and both sides are held in 1/256 percent.
    localparam longint ERR_HI       = 131071;
    localparam longint ERR_LO       = -131072;
    localparam longint I32_HI       = 64'sd2147483647;
    localparam longint I32_LO       = -64'sd2147483648;
    localparam longint WINDOW_Q8    = 70 * 256;
    localparam longint EFFORT_LIMIT = 60 * 256;
    localparam longint SIDE_LIMIT   = 100 * 256;
    localparam longint RING_FILL    = 9999;

    localparam logic signed [23:0] COUNT_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] COUNT_MIN = 24'sh800000;

    // One result word as the core presents it.
    typedef struct packed {
        logic signed [13:0] left;
        logic signed [13:0] right;
        logic signed [6:0]  effort;
        logic               settled;
    } t_drive_word;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [pdsc_pkg::CFG_AW-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_action;
    logic signed [23:0]            i_left_count;
    logic signed [23:0]            i_right_count;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic signed [13:0]            o_left_drive;
    logic signed [13:0]            o_right_drive;
    logic signed [6:0]             o_control_effort;
    logic                          o_settled;

    pi_drive_with_straight_correction_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_left_count     (i_left_count),
        .i_right_count    (i_right_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_left_drive     (o_left_drive),
        .o_right_drive    (o_right_drive),
        .o_control_effort (o_control_effort),
        .o_settled        (o_settled)
    );

    // Our own copy of the configuration registers, kept as wide signed numbers.
    longint target_mm;
    longint kp;
    longint ki;
    longint ks;
    longint mm_scale;
    longint settle_frac;

    // Our own copy of the controller state.
    longint integral_acc;
    longint err_ring [HIST];
    int     ring_ptr;
    bit     run_settled;

    // Expected result words, oldest first.
    t_drive_word pending_drive [$];

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned words_sent;
    int unsigned words_checked;
    int unsigned mismatches;
    int unsigned settles_seen;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random; the rate changes between the phases of the run.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic longint limit(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Uniform value in [-half, half].
    function automatic longint pick(longint half);
        return longint'($urandom_range(32'(2 * half))) - half;
    endfunction

    function automatic logic signed [23:0] rand_count();
        return 24'($urandom);
    endfunction

    // Register value in a typical range, with one draw in eight landing on an extreme.
    function automatic logic [15:0] pick_reg(int unsigned lo, int unsigned hi);
        if ($urandom_range(7) == 0) begin
            return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
        return 16'($urandom_range(hi, lo));
    endfunction

    // A restart clears the integral, refills the settle history and drops the settled flag.
    function automatic void clear_run();
        integral_acc = 0;
        foreach (err_ring[i]) err_ring[i] = RING_FILL;
        ring_ptr    = 0;
        run_settled = 1'b0;
    endfunction

    // Works out the result word that one accepted input word causes and queues it.
    function automatic void predict_drive(input logic act, input logic signed [23:0] l,
                                          input logic signed [23:0] r);
        longint      lc;
        longint      rc;
        longint      num;
        longint      err;
        longint      u;
        longint      diff;
        longint      ul;
        longint      ur;
        longint      tol;
        longint      older;
        t_drive_word w;
        w = '0;
        if (act) begin
            clear_run();
        end else if (run_settled) begin
            // Zero drive is latched once the run has settled.
            w.settled = 1'b1;
        end else begin
            lc  = l;
            rc  = r;
            // Position is (left+right)*scale/2^17 mm; the error is truncated toward zero.
            num = target_mm * 131072 - (lc + rc) * mm_scale;
            err = limit(num / 131072, ERR_LO, ERR_HI);
            u   = kp * err + ki * integral_acc;
            // Conditional integration: only while the raw output is inside the window.
            if (mag(u) < WINDOW_Q8) begin
                integral_acc = limit(integral_acc + err, I32_LO, I32_HI);
            end
            u = limit(u, -EFFORT_LIMIT, EFFORT_LIMIT);
            // The slot due for the next write holds the error from HIST-1 ticks ago.
            err_ring[ring_ptr] = err;
            ring_ptr = (ring_ptr + 1) % HIST;
            older    = err_ring[ring_ptr];
            diff = ks * (rc - lc);
            ur   = limit(u - diff, -SIDE_LIMIT, SIDE_LIMIT);
            ul   = limit(u + diff, -SIDE_LIMIT, SIDE_LIMIT);
            tol  = mag(target_mm) * settle_frac;
            w.effort = 7'(u / 256);
            if (mag(err) * 65536 <= tol && mag(older) * 65536 <= tol) begin
                // The settling tick itself still reports this tick's effort.
                run_settled = 1'b1;
                w.settled   = 1'b1;
                settles_seen++;
            end else begin
                w.left  = 14'((ul * 50) / 256);
                w.right = 14'((ur * 50) / 256);
            end
        end
        pending_drive.push_back(w);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result word %0d: %s", words_checked, msg);
        mismatches++;
    endtask

    // Every accepted result word is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_drive_word want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_drive.size() == 0) begin
                report_mismatch($sformatf("unexpected word, drives %0d/%0d effort %0d",
                                          o_left_drive, o_right_drive, o_control_effort));
            end else begin
                want = pending_drive.pop_front();
                if (o_left_drive !== want.left)
                    report_mismatch($sformatf("left_drive %0d, expected %0d",
                                              o_left_drive, want.left));
                if (o_right_drive !== want.right)
                    report_mismatch($sformatf("right_drive %0d, expected %0d",
                                              o_right_drive, want.right));
                if (o_control_effort !== want.effort)
                    report_mismatch($sformatf("control_effort %0d, expected %0d",
                                              o_control_effort, want.effort));
                if (o_settled !== want.settled)
                    report_mismatch($sformatf("settled %0b, expected %0b",
                                              o_settled, want.settled));
                words_checked++;
            end
        end
    end

    // Sends one input word. Called at a falling edge and returns at one, with valid low.
    task automatic send_word(input logic act, input logic signed [23:0] l,
                             input logic signed [23:0] r);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_action      = act;
        i_left_count  = l;
        i_right_count = r;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_drive(act, l, r);
        words_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Register write: setup cycle, then access cycle; the write lands when pready is high.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {16'h0000, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            pdsc_pkg::REG_TARGET:   target_mm   = longint'($signed(value));
            pdsc_pkg::REG_PROP:     kp          = value;
            pdsc_pkg::REG_INTEG:    ki          = value;
            pdsc_pkg::REG_STRAIGHT: ks          = value;
            pdsc_pkg::REG_MPC:      mm_scale    = value;
            pdsc_pkg::REG_SETTLE:   settle_frac = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Registers change only once every result is back and the sequencer has gone quiet.
    task automatic await_idle();
        while (pending_drive.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic set_idling(input int unsigned sender, input int unsigned receiver);
        send_idle_pct = sender;
        stall_pct     = receiver;
    endtask

    // Extremes of every count field at the reset settings, plus a restart.
    task automatic test_field_extremes();
        send_word(1'b1, COUNT_MAX, COUNT_MIN);
        send_word(1'b0, 24'sd0, 24'sd0);
        send_word(1'b0, COUNT_MAX, COUNT_MIN);
        send_word(1'b0, COUNT_MIN, COUNT_MAX);
        // Both counts at one extreme saturate the error in each direction.
        send_word(1'b0, COUNT_MAX, COUNT_MAX);
        send_word(1'b0, COUNT_MIN, COUNT_MIN);
    endtask

    // Every register at its top value, then at its bottom value.
    task automatic test_gain_extremes();
        await_idle();
        write_reg(pdsc_pkg::REG_TARGET, 16'h7FFF);
        write_reg(pdsc_pkg::REG_PROP, 16'hFFFF);
        write_reg(pdsc_pkg::REG_INTEG, 16'hFFFF);
        write_reg(pdsc_pkg::REG_STRAIGHT, 16'hFFFF);
        write_reg(pdsc_pkg::REG_MPC, 16'hFFFF);
        write_reg(pdsc_pkg::REG_SETTLE, 16'hFFFF);
        send_word(1'b0, COUNT_MAX, COUNT_MIN);
        // This one lands inside the wide tolerance and settles.
        send_word(1'b0, 24'sd1000, 24'sd1000);
        send_word(1'b0, COUNT_MIN, COUNT_MIN);
        await_idle();
        write_reg(pdsc_pkg::REG_TARGET, 16'h8000);
        write_reg(pdsc_pkg::REG_PROP, 16'h0000);
        write_reg(pdsc_pkg::REG_INTEG, 16'h0000);
        write_reg(pdsc_pkg::REG_STRAIGHT, 16'h0000);
        write_reg(pdsc_pkg::REG_MPC, 16'h0000);
        write_reg(pdsc_pkg::REG_SETTLE, 16'h0000);
        send_word(1'b1, 24'sd0, 24'sd0);
        send_word(1'b0, COUNT_MAX, COUNT_MAX);
        send_word(1'b0, 24'sd0, 24'sd0);
    endtask

    // Settling on the first tick, a tick after settling, and a restart that clears it.
    task automatic test_settle_and_restart();
        await_idle();
        write_reg(pdsc_pkg::REG_TARGET, 16'd20000);
        write_reg(pdsc_pkg::REG_PROP, pdsc_pkg::RST_PROP);
        write_reg(pdsc_pkg::REG_INTEG, pdsc_pkg::RST_INTEG);
        write_reg(pdsc_pkg::REG_STRAIGHT, pdsc_pkg::RST_STRAIGHT);
        write_reg(pdsc_pkg::REG_MPC, pdsc_pkg::RST_MPC);
        write_reg(pdsc_pkg::REG_SETTLE, 16'hFFFF);
        send_word(1'b1, 24'sd0, 24'sd0);
        send_word(1'b0, 24'sd55000, 24'sd56000);
        send_word(1'b0, COUNT_MAX, COUNT_MIN);
        send_word(1'b1, COUNT_MIN, COUNT_MAX);
        // Just outside the tolerance: the error equals the target.
        send_word(1'b0, 24'sd0, 24'sd0);
    endtask

    // Random settings for one run, extremes included now and then.
    task automatic pick_config();
        logic [15:0] tgt;
        if ($urandom_range(7) == 0)
            tgt = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        else
            tgt = 16'($urandom_range(40000) - 20000);
        write_reg(pdsc_pkg::REG_TARGET, tgt);
        write_reg(pdsc_pkg::REG_PROP, pick_reg(16, 2048));
        write_reg(pdsc_pkg::REG_INTEG, pick_reg(0, 256));
        write_reg(pdsc_pkg::REG_STRAIGHT, pick_reg(0, 1024));
        write_reg(pdsc_pkg::REG_MPC, pick_reg(4096, 40000));
        write_reg(pdsc_pkg::REG_SETTLE, pick_reg(1000, 16000));
    endtask

    // One run: restart, ramp the wheels toward the target, then hold near it long enough
    // for the history to fill so the run can settle. One run in five is cut short.
    task automatic drive_run();
        longint span;
        longint tolc;
        longint sum;
        longint skew;
        longint lc;
        longint rc;
        int     ramp;
        int     hold;
        int     post;
        send_word(1'b1, rand_count(), rand_count());
        span = (mm_scale == 0) ? 0 :
               limit(target_mm * 131072 / mm_scale, -15000000, 15000000);
        tolc = (mm_scale == 0) ? 0 :
               limit(mag(target_mm) * settle_frac / mm_scale, 0, 1000000);
        ramp = $urandom_range(12, 3);
        hold = ($urandom_range(4) == 0) ? $urandom_range(HIST - 2, 1)
                                        : $urandom_range(HIST + 10, HIST + 2);
        post = $urandom_range(4, 1);
        for (int k = 0; k < ramp + hold + post; k++) begin
            if (k < ramp)
                sum = span * k / ramp + pick(mag(span) / 8);
            else
                sum = span + pick(tolc / 2);
            skew = ($urandom_range(3) == 0) ? pick(2000) : pick(20);
            lc   = sum / 2 - skew;
            rc   = sum - sum / 2 + skew;
            send_word(1'b0, 24'(lc), 24'(rc));
        end
    endtask

    // Mostly well-formed runs under fresh settings, with bursts of random noise words.
    task automatic test_random_runs(input int unsigned quota);
        int unsigned start;
        start = words_sent;
        while (words_sent - start < quota) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(8, 1))
                    send_word($urandom_range(15) == 0, rand_count(), rand_count());
            end else begin
                await_idle();
                pick_config();
                drive_run();
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_action      = 1'b0;
        i_left_count  = '0;
        i_right_count = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        words_sent    = 0;
        words_checked = 0;
        mismatches    = 0;
        settles_seen  = 0;
        target_mm     = longint'($signed(pdsc_pkg::RST_TARGET));
        kp            = pdsc_pkg::RST_PROP;
        ki            = pdsc_pkg::RST_INTEG;
        ks            = pdsc_pkg::RST_STRAIGHT;
        mm_scale      = pdsc_pkg::RST_MPC;
        settle_frac   = pdsc_pkg::RST_SETTLE;
        clear_run();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Light sender gaps against a receiver that stalls most of the time.
        set_idling(14, 87);
        test_field_extremes();
        test_gain_extremes();
        test_settle_and_restart();
        test_random_runs(300);
        // Sparse sender against a mostly ready receiver.
        set_idling(87, 14);
        test_random_runs(300);
        // Back to back in both directions.
        set_idling(0, 0);
        test_random_runs(290);

        while (pending_drive.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("Sent %0d input words: field and register extremes, %0d settled runs,",
                 words_sent, settles_seen);
        $display("and three idling mixes; %0d result words checked.",
                 words_checked);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/pdsc_pkg.sv
rtl/pdsc_datapath.sv
rtl/pi_drive_with_straight_correction_core.sv
sim/pi_drive_with_straight_correction_core_tb.sv
